FILE: sv/bpd_pkg.sv
// ----------------------------------------------------------------------------
// bpd_pkg
// Shared types, register codes, reset values and the byte-wide crc update
// for the bit-stream packet deframer.
// ----------------------------------------------------------------------------
package bpd_pkg;

    localparam int SYNC_BITS_DEFAULT = 16;

    localparam int CHECK_W = 16;
    localparam int BYTE_W  = 8;
    localparam int LEFT_W  = 9;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        EVT_SYNC    = 2'd0,
        EVT_LENGTH  = 2'd1,
        EVT_PAYLOAD = 2'd2,
        EVT_END     = 2'd3
    } event_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_PATTERN = 2'd0,
        CFG_CRC_SEED     = 2'd1,
        CFG_CRC_POLY     = 2'd2,
        CFG_CRC_OUT_XOR  = 2'd3
    } cfg_index_t;

    localparam logic [CHECK_W-1:0] SYNC_PATTERN_RST = 16'h2DCA;
    localparam logic [CHECK_W-1:0] CRC_SEED_RST     = 16'h1D0F;
    localparam logic [CHECK_W-1:0] CRC_POLY_RST     = 16'h1021;
    localparam logic [CHECK_W-1:0] CRC_OUT_XOR_RST  = 16'hFFFF;

    // msb-first crc over one byte, eight shift steps
    function automatic logic [CHECK_W-1:0] crc_byte(
        input logic [CHECK_W-1:0] crc_in,
        input logic [BYTE_W-1:0]  data,
        input logic [CHECK_W-1:0] poly
    );
        logic [CHECK_W-1:0] c;
        c = crc_in ^ {data, {(CHECK_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[CHECK_W-1])
            begin
                c = {c[CHECK_W-2:0], 1'b0} ^ poly;
            end
            else
            begin
                c = {c[CHECK_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: sv/bitstream_packet_deframer_crc16.sv
// ----------------------------------------------------------------------------
// bitstream_packet_deframer_crc16
// Sync-word hunt, length-prefixed byte framing and crc-16 check on a bit stream.
// ----------------------------------------------------------------------------
// One received bit is taken per clock cycle while in_stall is low. An accepted
// bit sits in an input register; combinational framing logic (hunt compare,
// byte assembly and a byte-wide crc update) works on it, and when the bit moves
// on, it updates the frame state and loads the result register, from which the
// result is shown. While a result waits to be taken, bits that give no result
// still flow; a bit that gives a result waits in the input register. Events:
// sync found, length byte, each payload byte, and frame end with the crc
// verdict. SYNC_BITS sets the hunt register width; the 16-bit pattern is
// zero-extended or truncated to it. Configuration registers are read live and
// should be written only while the block is idle.
module bitstream_packet_deframer_crc16 #(
    parameter int SYNC_BITS = bpd_pkg::SYNC_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [bpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bpd_pkg::CHECK_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          bit_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output bpd_pkg::event_kind_t          event_kind,
    output logic [bpd_pkg::BYTE_W-1:0]    byte_value,
    output logic                          check_ok,
    output logic [bpd_pkg::CHECK_W-1:0]   computed_check,
    output logic [bpd_pkg::CHECK_W-1:0]   received_check
);
    import bpd_pkg::*;

    logic [CHECK_W-1:0]   sync_pattern_reg;
    logic [CHECK_W-1:0]   crc_seed_reg;
    logic [CHECK_W-1:0]   poly_reg;
    logic [CHECK_W-1:0]   crc_out_xor_reg;

    logic                 bit_valid_reg;
    logic                 bit_reg;

    logic [SYNC_BITS-1:0] hunt_reg,      hunt_next;
    logic                 locked_reg,    locked_next;
    logic [2:0]           bit_count_reg, bit_count_next;
    logic [BYTE_W-1:0]    byte_reg,      byte_next;
    logic                 want_len_reg,  want_len_next;
    logic [LEFT_W-1:0]    left_reg,      left_next;
    logic [CHECK_W-1:0]   crc_reg,       crc_next;
    logic [CHECK_W-1:0]   rx_check_reg,  rx_check_next;

    logic                 out_valid_reg;
    event_kind_t          kind_reg,      kind_next;
    logic [BYTE_W-1:0]    obyte_reg,     obyte_next;
    logic                 ok_reg,        ok_next;
    logic [CHECK_W-1:0]   comp_reg,      comp_next;
    logic [CHECK_W-1:0]   recv_reg,      recv_next;

    logic                 has_result;
    logic                 fire;
    logic [31:0]          pattern_ext;
    logic [SYNC_BITS-1:0] sync_cmp;
    logic [SYNC_BITS-1:0] hunt_shifted;
    logic [CHECK_W-1:0]   crc_upd;
    logic [CHECK_W-1:0]   crc_final;
    logic [LEFT_W-1:0]    left_after;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_pattern_reg <= SYNC_PATTERN_RST;
            crc_seed_reg     <= CRC_SEED_RST;
            poly_reg         <= CRC_POLY_RST;
            crc_out_xor_reg  <= CRC_OUT_XOR_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SYNC_PATTERN: sync_pattern_reg <= cfg_data;
                CFG_CRC_SEED:     crc_seed_reg     <= cfg_data;
                CFG_CRC_POLY:     poly_reg         <= cfg_data;
                CFG_CRC_OUT_XOR:  crc_out_xor_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign pattern_ext  = 32'(sync_pattern_reg);
    assign sync_cmp     = pattern_ext[SYNC_BITS-1:0];
    assign hunt_shifted = {hunt_reg[SYNC_BITS-2:0], bit_reg};
    assign crc_upd      = crc_byte(crc_reg, {byte_reg[BYTE_W-2:0], bit_reg}, poly_reg);

    // framing step for the bit held in the input register
    always_comb
    begin
        hunt_next      = hunt_reg;
        locked_next    = locked_reg;
        bit_count_next = bit_count_reg;
        byte_next      = byte_reg;
        want_len_next  = want_len_reg;
        left_next      = left_reg;
        crc_next       = crc_reg;
        rx_check_next  = rx_check_reg;
        has_result     = 1'b0;
        kind_next      = EVT_SYNC;
        obyte_next     = '0;
        ok_next        = 1'b0;
        comp_next      = '0;
        recv_next      = '0;
        left_after     = left_reg;
        crc_final      = crc_reg ^ crc_out_xor_reg;

        if (!locked_reg)
        begin
            hunt_next = hunt_shifted;
            if (hunt_shifted == sync_cmp)
            begin
                locked_next    = 1'b1;
                bit_count_next = '0;
                crc_next       = crc_seed_reg;
                want_len_next  = 1'b1;
                left_next      = '0;
                has_result     = 1'b1;
                kind_next      = EVT_SYNC;
            end
        end
        else
        begin
            byte_next      = {byte_reg[BYTE_W-2:0], bit_reg};
            bit_count_next = bit_count_reg + 3'd1;
            if (bit_count_next == 3'd0)
            begin
                if (want_len_reg)
                begin
                    want_len_next = 1'b0;
                    left_next     = LEFT_W'(byte_next) + LEFT_W'(2);
                    crc_next      = crc_upd;
                    has_result    = 1'b1;
                    kind_next     = EVT_LENGTH;
                    obyte_next    = byte_next;
                end
                else if (left_reg > LEFT_W'(2))
                begin
                    crc_next   = crc_upd;
                    left_next  = left_reg - LEFT_W'(1);
                    has_result = 1'b1;
                    kind_next  = EVT_PAYLOAD;
                    obyte_next = byte_next;
                end
                else
                begin
                    // received crc bytes, big-endian; frame ends on the second
                    if (left_reg != '0)
                    begin
                        rx_check_next = {rx_check_reg[CHECK_W-BYTE_W-1:0], byte_next};
                        left_after    = left_reg - LEFT_W'(1);
                        left_next     = left_after;
                    end
                    if (left_after == '0)
                    begin
                        crc_next    = crc_final;
                        locked_next = 1'b0;
                        has_result  = 1'b1;
                        kind_next   = EVT_END;
                        ok_next     = (crc_final == rx_check_next);
                        comp_next   = crc_final;
                        recv_next   = rx_check_next;
                    end
                end
            end
        end
    end

    // bits with no result move on even while the result register is full
    assign fire     = bit_valid_reg && (!has_result || !out_valid_reg || !out_stall);
    assign in_stall = bit_valid_reg && !fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            bit_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            bit_reg <= bit_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunt_reg      <= '0;
            locked_reg    <= 1'b0;
            bit_count_reg <= '0;
            byte_reg      <= '0;
            want_len_reg  <= 1'b0;
            left_reg      <= '0;
            crc_reg       <= CRC_SEED_RST;
            rx_check_reg  <= '0;
        end
        else if (fire)
        begin
            hunt_reg      <= hunt_next;
            locked_reg    <= locked_next;
            bit_count_reg <= bit_count_next;
            byte_reg      <= byte_next;
            want_len_reg  <= want_len_next;
            left_reg      <= left_next;
            crc_reg       <= crc_next;
            rx_check_reg  <= rx_check_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && has_result)
        begin
            kind_reg  <= kind_next;
            obyte_reg <= obyte_next;
            ok_reg    <= ok_next;
            comp_reg  <= comp_next;
            recv_reg  <= recv_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_kind     = kind_reg;
    assign byte_value     = obyte_reg;
    assign check_ok       = ok_reg;
    assign computed_check = comp_reg;
    assign received_check = recv_reg;

endmodule
